// File: rtl/wsg_pkg.sv
package wsg_pkg;

    // Field widths
    localparam int LEN_W = 14;
    localparam int HALF_W = LEN_W - 1;
    localparam int ANG_W = 34;
    localparam int MAX_TABLE_LENGTH = 16383;

    // Angles and fractions in Q30
    localparam logic [63:0] PI_Q30_W = 64'd3373259426;
    localparam logic [30:0] HALF_PI_Q30 = 31'(PI_Q30_W >> 1);
    localparam logic [32:0] TWO_PI_Q30 = 33'(PI_Q30_W << 1);
    localparam logic [63:0] PI_SQ_FULL = PI_Q30_W * PI_Q30_W;
    localparam logic [33:0] PI_SQ_Q30 = 34'(PI_SQ_FULL >> 30);
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [29:0] HAM_A_Q30 = 30'd579820585;
    localparam logic [29:0] HAM_B_Q30 = 30'd493921239;

    // Taylor series: divisors (n-1)*n and their 2^32 reciprocals (floored)
    localparam int N_TERMS = 7;
    localparam logic [8:0] SIN_DIV [N_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210};
    localparam logic [8:0] COS_DIV [N_TERMS] = '{
        9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182};
    localparam logic [31:0] SIN_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd210)};
    localparam logic [31:0] COS_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd182)};

    typedef logic [ANG_W-1:0] ang_t;
    typedef logic signed [ANG_W-1:0] trig_t;

endpackage

// File: rtl/wsg_div.sv
module wsg_div #(
    parameter int DVS_W = 13,
    parameter int QUOT_W = 34,
    parameter int TAG_W = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [QUOT_W+DVS_W-1:0] in_dividend,
    input  logic [DVS_W-1:0]        in_divisor,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic [QUOT_W-1:0]       out_quot,
    output logic [TAG_W-1:0]        out_tag
);

    logic [QUOT_W-1:0] vld_reg;
    logic [DVS_W-1:0]  rem_reg  [QUOT_W];
    logic [QUOT_W-1:0] low_reg  [QUOT_W];
    logic [QUOT_W-1:0] quot_reg [QUOT_W];
    logic [DVS_W-1:0]  dvs_reg  [QUOT_W];
    logic [TAG_W-1:0]  tag_reg  [QUOT_W];

    logic [DVS_W-1:0]  rem_next  [QUOT_W];
    logic [QUOT_W-1:0] low_next  [QUOT_W];
    logic [QUOT_W-1:0] quot_next [QUOT_W];
    logic [DVS_W-1:0]  dvs_next  [QUOT_W];
    logic [TAG_W-1:0]  tag_next  [QUOT_W];

    // One quotient bit per stage: shift in a dividend bit, trial subtract
    for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
        logic [DVS_W-1:0]  prev_rem;
        logic [QUOT_W-1:0] prev_low;
        logic [QUOT_W-1:0] prev_quot;
        logic [DVS_W:0]    trial;
        logic [DVS_W:0]    diff;
        logic              take;

        if (i == 0) begin : g_first
            assign prev_rem    = in_dividend[QUOT_W+DVS_W-1:QUOT_W];
            assign prev_low    = in_dividend[QUOT_W-1:0];
            assign prev_quot   = '0;
            assign dvs_next[i] = in_divisor;
            assign tag_next[i] = in_tag;
        end else begin : g_rest
            assign prev_rem    = rem_reg[i-1];
            assign prev_low    = low_reg[i-1];
            assign prev_quot   = quot_reg[i-1];
            assign dvs_next[i] = dvs_reg[i-1];
            assign tag_next[i] = tag_reg[i-1];
        end

        assign trial        = {prev_rem, prev_low[QUOT_W-1]};
        assign diff         = trial - {1'b0, dvs_next[i]};
        assign take         = (trial >= {1'b0, dvs_next[i]});
        assign rem_next[i]  = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        assign low_next[i]  = prev_low << 1;
        assign quot_next[i] = {prev_quot[QUOT_W-2:0], take};
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUOT_W-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QUOT_W; i++) begin
                rem_reg[i]  <= rem_next[i];
                low_reg[i]  <= low_next[i];
                quot_reg[i] <= quot_next[i];
                dvs_reg[i]  <= dvs_next[i];
                tag_reg[i]  <= tag_next[i];
            end
        end
    end

    assign out_valid = vld_reg[QUOT_W-1];
    assign out_quot  = quot_reg[QUOT_W-1];
    assign out_tag   = tag_reg[QUOT_W-1];

endmodule

// File: rtl/wsg_sincos.sv
module wsg_sincos #(
    parameter int TAG_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  wsg_pkg::ang_t       in_angle,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output wsg_pkg::trig_t      out_sin,
    output wsg_pkg::trig_t      out_cos,
    output logic [TAG_W-1:0]    out_tag
);

    localparam int N = wsg_pkg::N_TERMS;
    localparam int NSTG = 3 + 3 * N + 1;
    localparam logic [32:0] H1 = 33'(wsg_pkg::HALF_PI_Q30);
    localparam logic [32:0] H2 = 33'(wsg_pkg::HALF_PI_Q30) << 1;
    localparam logic [32:0] H3 = H1 + H2;

    logic [NSTG-1:0]  vld_reg;
    logic [TAG_W-1:0] tag_reg [NSTG];

    // Front stages: reduce, split into quadrant, square
    logic [32:0] r0_reg;
    logic [30:0] f1_reg;
    logic [1:0]  q1_reg;
    logic [30:0] f2_reg;
    logic [31:0] x2_reg;
    logic [1:0]  q2_reg;
    logic [32:0] r0_next;
    logic [30:0] f1_next;
    logic [1:0]  q1_next;
    logic [61:0] fsq;

    // Series steps, three stages each
    logic [31:0]        st_ts [N];
    logic [31:0]        st_tc [N];
    wsg_pkg::trig_t     st_ss [N];
    wsg_pkg::trig_t     st_sc [N];
    logic [31:0]        st_x2 [N];
    logic [1:0]         st_q  [N];

    logic [31:0]        a_ps_reg [N];
    logic [31:0]        a_pc_reg [N];
    wsg_pkg::trig_t     a_ss_reg [N];
    wsg_pkg::trig_t     a_sc_reg [N];
    logic [31:0]        a_x2_reg [N];
    logic [1:0]         a_q_reg  [N];

    logic [31:0]        b_ps_reg [N];
    logic [31:0]        b_pc_reg [N];
    logic [31:0]        b_qs_reg [N];
    logic [31:0]        b_qc_reg [N];
    wsg_pkg::trig_t     b_ss_reg [N];
    wsg_pkg::trig_t     b_sc_reg [N];
    logic [31:0]        b_x2_reg [N];
    logic [1:0]         b_q_reg  [N];

    logic [31:0]        c_ts_reg [N];
    logic [31:0]        c_tc_reg [N];
    wsg_pkg::trig_t     c_ss_reg [N];
    wsg_pkg::trig_t     c_sc_reg [N];
    logic [31:0]        c_x2_reg [N];
    logic [1:0]         c_q_reg  [N];

    logic [31:0]        a_ps_next [N];
    logic [31:0]        a_pc_next [N];
    logic [31:0]        b_qs_next [N];
    logic [31:0]        b_qc_next [N];
    logic [31:0]        c_ts_next [N];
    logic [31:0]        c_tc_next [N];
    wsg_pkg::trig_t     c_ss_next [N];
    wsg_pkg::trig_t     c_sc_next [N];

    wsg_pkg::trig_t     sin_reg;
    wsg_pkg::trig_t     cos_reg;
    wsg_pkg::trig_t     sin_next;
    wsg_pkg::trig_t     cos_next;

    // Reduce modulo 2*pi and pick the quadrant
    always_comb begin
        if (in_angle >= 34'(wsg_pkg::TWO_PI_Q30)) begin
            r0_next = 33'(in_angle - 34'(wsg_pkg::TWO_PI_Q30));
        end else begin
            r0_next = in_angle[32:0];
        end
        if (r0_reg >= H3) begin
            q1_next = 2'd3;
            f1_next = 31'(r0_reg - H3);
        end else if (r0_reg >= H2) begin
            q1_next = 2'd2;
            f1_next = 31'(r0_reg - H2);
        end else if (r0_reg >= H1) begin
            q1_next = 2'd1;
            f1_next = 31'(r0_reg - H1);
        end else begin
            q1_next = 2'd0;
            f1_next = r0_reg[30:0];
        end
    end

    assign fsq = 62'(f1_reg) * 62'(f1_reg);

    // Taylor terms: multiply by x^2, divide by (n-1)*n via reciprocal, correct
    for (genvar k = 0; k < N; k++) begin : g_term
        logic [63:0] mul_s;
        logic [63:0] mul_c;
        logic [63:0] rcp_s;
        logic [63:0] rcp_c;
        logic [31:0] rem_s;
        logic [31:0] rem_c;
        logic [31:0] qs;
        logic [31:0] qc;

        if (k == 0) begin : g_first
            assign st_ts[k] = 32'(f2_reg);
            assign st_tc[k] = wsg_pkg::ONE_Q30;
            assign st_ss[k] = $signed(34'(f2_reg));
            assign st_sc[k] = $signed(34'(wsg_pkg::ONE_Q30));
            assign st_x2[k] = x2_reg;
            assign st_q[k]  = q2_reg;
        end else begin : g_rest
            assign st_ts[k] = c_ts_reg[k-1];
            assign st_tc[k] = c_tc_reg[k-1];
            assign st_ss[k] = c_ss_reg[k-1];
            assign st_sc[k] = c_sc_reg[k-1];
            assign st_x2[k] = c_x2_reg[k-1];
            assign st_q[k]  = c_q_reg[k-1];
        end

        assign mul_s        = 64'(st_ts[k]) * 64'(st_x2[k]);
        assign mul_c        = 64'(st_tc[k]) * 64'(st_x2[k]);
        assign a_ps_next[k] = mul_s[61:30];
        assign a_pc_next[k] = mul_c[61:30];

        assign rcp_s        = 64'(a_ps_reg[k]) * 64'(wsg_pkg::SIN_RECIP[k]);
        assign rcp_c        = 64'(a_pc_reg[k]) * 64'(wsg_pkg::COS_RECIP[k]);
        assign b_qs_next[k] = rcp_s[63:32];
        assign b_qc_next[k] = rcp_c[63:32];

        assign rem_s = b_ps_reg[k] - 32'(b_qs_reg[k] * 32'(wsg_pkg::SIN_DIV[k]));
        assign rem_c = b_pc_reg[k] - 32'(b_qc_reg[k] * 32'(wsg_pkg::COS_DIV[k]));
        assign qs    = (rem_s >= 32'(wsg_pkg::SIN_DIV[k])) ? b_qs_reg[k] + 32'd1
                                                          : b_qs_reg[k];
        assign qc    = (rem_c >= 32'(wsg_pkg::COS_DIV[k])) ? b_qc_reg[k] + 32'd1
                                                          : b_qc_reg[k];
        assign c_ts_next[k] = qs;
        assign c_tc_next[k] = qc;

        // Signs alternate, first correction subtracts
        if ((k % 2) == 0) begin : g_sub
            assign c_ss_next[k] = b_ss_reg[k] - $signed({2'b00, qs});
            assign c_sc_next[k] = b_sc_reg[k] - $signed({2'b00, qc});
        end else begin : g_add
            assign c_ss_next[k] = b_ss_reg[k] + $signed({2'b00, qs});
            assign c_sc_next[k] = b_sc_reg[k] + $signed({2'b00, qc});
        end
    end

    // Map signs by quadrant
    always_comb begin
        case (c_q_reg[N-1])
            2'd0: begin
                sin_next = c_ss_reg[N-1];
                cos_next = c_sc_reg[N-1];
            end
            2'd1: begin
                sin_next = c_sc_reg[N-1];
                cos_next = -c_ss_reg[N-1];
            end
            2'd2: begin
                sin_next = -c_ss_reg[N-1];
                cos_next = -c_sc_reg[N-1];
            end
            default: begin
                sin_next = -c_sc_reg[N-1];
                cos_next = c_ss_reg[N-1];
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < NSTG; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
            r0_reg <= r0_next;
            f1_reg <= f1_next;
            q1_reg <= q1_next;
            f2_reg <= f1_reg;
            q2_reg <= q1_reg;
            x2_reg <= fsq[61:30];
            for (int k = 0; k < N; k++) begin
                a_ps_reg[k] <= a_ps_next[k];
                a_pc_reg[k] <= a_pc_next[k];
                a_ss_reg[k] <= st_ss[k];
                a_sc_reg[k] <= st_sc[k];
                a_x2_reg[k] <= st_x2[k];
                a_q_reg[k]  <= st_q[k];
                b_ps_reg[k] <= a_ps_reg[k];
                b_pc_reg[k] <= a_pc_reg[k];
                b_qs_reg[k] <= b_qs_next[k];
                b_qc_reg[k] <= b_qc_next[k];
                b_ss_reg[k] <= a_ss_reg[k];
                b_sc_reg[k] <= a_sc_reg[k];
                b_x2_reg[k] <= a_x2_reg[k];
                b_q_reg[k]  <= a_q_reg[k];
                c_ts_reg[k] <= c_ts_next[k];
                c_tc_reg[k] <= c_tc_next[k];
                c_ss_reg[k] <= c_ss_next[k];
                c_sc_reg[k] <= c_sc_next[k];
                c_x2_reg[k] <= b_x2_reg[k];
                c_q_reg[k]  <= b_q_reg[k];
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;
    assign out_tag   = tag_reg[NSTG-1];

endmodule

// File: rtl/windowed_sinc_coefficient_gen_unit.sv
// Channel   Direction  Ports                                   Beat
// s_        in         s_valid, s_ready, s_index               one table index
// m_        out        m_valid, m_ready, m_coefficient,        one coefficient
//                      m_length_error
// cfg_      in         cfg_valid, cfg_ready, cfg_table_length  table length write
//
// One index enters per cycle while the pipeline is not held; a result passes
// through the two 34-stage argument dividers, the 32-stage sinc divider and
// the 25-stage sine/cosine series pipeline.
// aresetn (synchronous, active low) empties the pipeline and sets the table
// length to 2047. The whole pipeline holds only when the output register is
// full, not taken, and the last stage carries a result.
module windowed_sinc_coefficient_gen_unit #(
    parameter int COEF_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [13:0]                 cfg_table_length,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [13:0]                 s_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [COEF_BITS-1:0] m_coefficient,
    output logic                        m_length_error
);

    localparam int SHIFT = 61 - COEF_BITS;
    localparam int LEN_W = wsg_pkg::LEN_W;
    localparam int HALF_W = wsg_pkg::HALF_W;
    localparam int ANG_W = wsg_pkg::ANG_W;
    localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_MIN = -(64'sd1 <<< (COEF_BITS - 1));
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (SHIFT - 1);

    logic [LEN_W-1:0] len_reg;
    logic             en;

    // Input stage
    logic              i_vld_reg;
    logic [LEN_W-1:0]  i_n_reg;
    logic [HALF_W-1:0] i_d_reg;
    logic              i_err_reg;
    logic              i_dz_reg;
    logic [HALF_W-1:0] h;
    logic [LEN_W-1:0]  d_full;
    logic              err_next;

    // Dividend stage
    logic              m_vld_reg;
    logic [46:0]       mu_reg;
    logic [47:0]       ma_reg;
    logic              m_err_reg;
    logic              m_dz_reg;

    // Divider and series outputs
    logic              du_valid;
    logic              da_valid;
    wsg_pkg::ang_t     u_quot;
    wsg_pkg::ang_t     a_quot;
    logic              du_dz;
    logic              da_err;
    logic              su_valid;
    logic              sa_valid;
    wsg_pkg::trig_t    su_sin;
    wsg_pkg::trig_t    su_cos;
    wsg_pkg::trig_t    sa_sin;
    wsg_pkg::trig_t    sa_cos;
    logic [ANG_W:0]    su_tag;
    logic              sa_tag;

    // Window and sinc divider set-up
    logic              w_vld_reg;
    wsg_pkg::trig_t    w_win_reg;
    logic [65:0]       w_dvd_reg;
    wsg_pkg::ang_t     w_u_reg;
    logic              w_neg_reg;
    logic              w_dz_reg;
    logic              w_err_reg;
    logic signed [63:0] bc;
    wsg_pkg::trig_t    win_next;
    wsg_pkg::ang_t     s_abs;

    logic              ds_valid;
    logic [31:0]       ds_quot;
    logic [ANG_W+2:0]  ds_tag;

    // Product and rounding stages
    logic              p1_vld_reg;
    wsg_pkg::trig_t    p1_sinc_reg;
    wsg_pkg::trig_t    p1_win_reg;
    logic              p1_err_reg;
    wsg_pkg::trig_t    sinc_next;
    logic              p2_vld_reg;
    logic signed [63:0] p2_prod_reg;
    logic              p2_err_reg;
    logic signed [67:0] prod_full;
    logic              p3_vld_reg;
    logic [COEF_BITS-1:0] p3_coef_reg;
    logic              p3_err_reg;
    logic signed [63:0] rnd;
    logic [COEF_BITS-1:0] coef_next;

    logic              out_vld_reg;
    logic [COEF_BITS-1:0] out_coef_reg;
    logic              out_err_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= 14'd2047;
        end else if (cfg_valid) begin
            len_reg <= cfg_table_length;
        end
    end

    // Hold everything only when the output is blocked and a result waits behind it
    assign en      = m_ready || !out_vld_reg || !p3_vld_reg;
    assign s_ready = en;

    // Check the length and index, find the distance from the centre
    assign h = len_reg[LEN_W-1:1];
    always_comb begin
        err_next = (len_reg < 14'd3) || !len_reg[0]
                || (32'(len_reg) > wsg_pkg::MAX_TABLE_LENGTH)
                || (s_index >= len_reg);
        if (s_index >= 14'(h)) begin
            d_full = s_index - 14'(h);
        end else begin
            d_full = 14'(h) - s_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            w_vld_reg   <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
        end else if (en) begin
            i_vld_reg   <= s_valid;
            m_vld_reg   <= i_vld_reg;
            w_vld_reg   <= su_valid;
            p1_vld_reg  <= ds_valid;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
        end
    end

    // Front payload: index, distance, then the two rounded dividends
    always_ff @(posedge aclk) begin
        if (en) begin
            i_n_reg   <= s_index;
            i_d_reg   <= d_full[HALF_W-1:0];
            i_err_reg <= err_next;
            i_dz_reg  <= (d_full == '0);
            mu_reg    <= 47'(wsg_pkg::PI_SQ_Q30) * 47'(i_d_reg) + 47'(h >> 1);
            ma_reg    <= 48'(wsg_pkg::TWO_PI_Q30) * 48'(i_n_reg) + 48'(len_reg >> 1);
            m_err_reg <= i_err_reg;
            m_dz_reg  <= i_dz_reg;
        end
    end

    // Sine argument u = pi^2*d/h and window angle a = 2*pi*n/L
    wsg_div #(.DVS_W(HALF_W), .QUOT_W(ANG_W), .TAG_W(1)) u_div_u (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (m_vld_reg),
        .in_dividend (mu_reg),
        .in_divisor  (h),
        .in_tag      (m_dz_reg),
        .out_valid   (du_valid),
        .out_quot    (u_quot),
        .out_tag     (du_dz)
    );

    wsg_div #(.DVS_W(LEN_W), .QUOT_W(ANG_W), .TAG_W(1)) u_div_a (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (m_vld_reg),
        .in_dividend (ma_reg),
        .in_divisor  (len_reg),
        .in_tag      (m_err_reg),
        .out_valid   (da_valid),
        .out_quot    (a_quot),
        .out_tag     (da_err)
    );

    wsg_sincos #(.TAG_W(ANG_W + 1)) u_sincos_u (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (du_valid),
        .in_angle  (u_quot),
        .in_tag    ({du_dz, u_quot}),
        .out_valid (su_valid),
        .out_sin   (su_sin),
        .out_cos   (su_cos),
        .out_tag   (su_tag)
    );

    wsg_sincos #(.TAG_W(1)) u_sincos_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (da_valid),
        .in_angle  (a_quot),
        .in_tag    (da_err),
        .out_valid (sa_valid),
        .out_sin   (sa_sin),
        .out_cos   (sa_cos),
        .out_tag   (sa_tag)
    );

    // Hamming window and the magnitude of sin(u) for the sinc division
    assign bc       = 64'(sa_cos) * $signed(64'(wsg_pkg::HAM_B_Q30));
    assign win_next = 34'($signed(64'(wsg_pkg::HAM_A_Q30)) - (bc >>> 30));
    assign s_abs    = su_sin[ANG_W-1] ? ANG_W'(-su_sin) : ANG_W'(su_sin);

    always_ff @(posedge aclk) begin
        if (en) begin
            w_win_reg <= win_next;
            w_dvd_reg <= {2'b00, s_abs, 30'd0};
            w_u_reg   <= su_tag[ANG_W-1:0];
            w_neg_reg <= su_sin[ANG_W-1];
            w_dz_reg  <= su_tag[ANG_W];
            w_err_reg <= sa_tag;
        end
    end

    wsg_div #(.DVS_W(ANG_W), .QUOT_W(32), .TAG_W(ANG_W + 3)) u_div_sinc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (w_vld_reg),
        .in_dividend (w_dvd_reg),
        .in_divisor  (w_u_reg),
        .in_tag      ({w_win_reg, w_neg_reg, w_dz_reg, w_err_reg}),
        .out_valid   (ds_valid),
        .out_quot    (ds_quot),
        .out_tag     (ds_tag)
    );

    // Sinc with sign, exactly one at the centre entry
    always_comb begin
        if (ds_tag[1]) begin
            sinc_next = $signed(34'(wsg_pkg::ONE_Q30));
        end else if (ds_tag[2]) begin
            sinc_next = -$signed({2'b00, ds_quot});
        end else begin
            sinc_next = $signed({2'b00, ds_quot});
        end
    end

    assign prod_full = 68'(p1_sinc_reg) * 68'(p1_win_reg);

    // Round half up to the output format and saturate; an error beat gives zero
    always_comb begin
        rnd = (p2_prod_reg + RND_HALF) >>> SHIFT;
        if (p2_err_reg) begin
            coef_next = '0;
        end else if (rnd > SAT_MAX) begin
            coef_next = SAT_MAX[COEF_BITS-1:0];
        end else if (rnd < SAT_MIN) begin
            coef_next = SAT_MIN[COEF_BITS-1:0];
        end else begin
            coef_next = rnd[COEF_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_sinc_reg <= sinc_next;
            p1_win_reg  <= ds_tag[ANG_W+2:3];
            p1_err_reg  <= ds_tag[0];
            p2_prod_reg <= prod_full[63:0];
            p2_err_reg  <= p1_err_reg;
            p3_coef_reg <= coef_next;
            p3_err_reg  <= p2_err_reg;
        end
    end

    // Output register: load a finished beat, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en && p3_vld_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && p3_vld_reg) begin
            out_coef_reg <= p3_coef_reg;
            out_err_reg  <= p3_err_reg;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_coefficient  = $signed(out_coef_reg);
    assign m_length_error = out_err_reg;

`ifndef SYNTHESIS
    a_div_lockstep : assert property (@(posedge aclk) disable iff (!aresetn)
        du_valid == da_valid)
        else $error("argument and window dividers out of step");

    a_trig_lockstep : assert property (@(posedge aclk) disable iff (!aresetn)
        su_valid == sa_valid)
        else $error("sine/cosine units out of step");

    a_err_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        p3_vld_reg && p3_err_reg |-> p3_coef_reg == '0)
        else $error("error beat carries a non-zero coefficient");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_ready && p3_vld_reg |=> out_vld_reg && p3_vld_reg)
        else $error("waiting result lost while output blocked");
`endif

endmodule

// File: tb/windowed_sinc_coefficient_gen_unit_tb.sv
`timescale 1ns / 1ps

module windowed_sinc_coefficient_gen_unit_tb;

    localparam int COEF_W = 16;
    localparam int LATENCY = 97;
    localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (COEF_W - 1)) - 1;
    localparam logic signed [63:0] SAT_MIN = -(64'sd1 <<< (COEF_W - 1));
    localparam logic signed [63:0] Q30_ONE = 64'sd1 <<< 30;
    localparam logic signed [63:0] WIN_A = 64'sd579820585;
    localparam logic signed [63:0] WIN_B = Q30_ONE - WIN_A;
    localparam logic [63:0] PI_Q = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q = PI_Q / 2;
    localparam logic [63:0] TWO_PI_Q = PI_Q * 2;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic                     length_error;
    } coef_beat_t;

    // One directed row: length to program (0 keeps the current one), index, and
    // an optional typed-in expectation.
    typedef struct packed {
        logic [13:0]              length;
        logic [13:0]              index;
        logic                     known;
        logic signed [COEF_W-1:0] coefficient;
        logic                     length_error;
    } row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [13:0]              cfg_table_length;
    logic                     s_valid;
    logic                     s_ready;
    logic [13:0]              s_index;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [COEF_W-1:0] m_coefficient;
    logic                     m_length_error;

    logic [13:0] cur_length;
    coef_beat_t  coef_due_q[$];
    int          fail_count;
    bit          hold_off_req;
    int          beats_seen;

    windowed_sinc_coefficient_gen_unit #(.COEF_BITS(COEF_W)) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_table_length (cfg_table_length),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_index          (s_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_coefficient    (m_coefficient),
        .m_length_error   (m_length_error)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic signed [63:0] floor_q(input logic signed [63:0] v, input int s);
        floor_q = v >>> s;
    endfunction

    // Taylor-series sine and cosine of a Q30 angle, quadrant mapped
    function automatic void series_sin_cos(input logic [63:0] ang,
                                           output logic signed [63:0] sn,
                                           output logic signed [63:0] cs);
        logic [63:0] r, quad, f, x2, term;
        logic signed [63:0] s, c;
        bit neg;
        r = ang % TWO_PI_Q;
        quad = r / HALF_PI_Q;
        f = r - quad * HALF_PI_Q;
        x2 = (f * f) >> 30;
        s = f;
        c = Q30_ONE;
        term = f;
        neg = 1;
        for (int n = 3; n <= 15; n += 2) begin
            term = ((term * x2) >> 30) / ((n - 1) * n);
            s = neg ? s - $signed(term) : s + $signed(term);
            neg = !neg;
        end
        term = Q30_ONE;
        neg = 1;
        for (int n = 2; n <= 14; n += 2) begin
            term = ((term * x2) >> 30) / ((n - 1) * n);
            c = neg ? c - $signed(term) : c + $signed(term);
            neg = !neg;
        end
        case (quad[1:0])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    // Windowed sinc coefficient for one index under the given table length
    function automatic coef_beat_t windowed_sinc(input logic [13:0] len_in,
                                                 input logic [13:0] idx_in);
        logic [63:0] len, n, h, d, u, a, pi_sq;
        logic signed [63:0] s, c, sinc, win, prod, res;
        coef_beat_t r;
        len = len_in;
        n = idx_in;
        r = '0;
        if (len < 3 || len[0] == 1'b0 || len > wsg_pkg::MAX_TABLE_LENGTH || n >= len) begin
            r.length_error = 1'b1;
            return r;
        end
        h = (len - 1) / 2;
        d = (n >= h) ? n - h : h - n;
        if (d == 0) begin
            sinc = Q30_ONE;
        end else begin
            pi_sq = (PI_Q * PI_Q) >> 30;
            u = (pi_sq * d + h / 2) / h;
            series_sin_cos(u, s, c);
            sinc = (s * Q30_ONE) / $signed(u);
        end
        a = (TWO_PI_Q * n + len / 2) / len;
        series_sin_cos(a, s, c);
        win = WIN_A - floor_q(WIN_B * c, 30);
        prod = sinc * win;
        res = floor_q(prod + (64'sd1 <<< (61 - COEF_W - 1)), 61 - COEF_W);
        if (res > SAT_MAX) res = SAT_MAX;
        if (res < SAT_MIN) res = SAT_MIN;
        r.coefficient = res[COEF_W-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_drained();
        while (coef_due_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    // Write the table length while the block is idle
    task automatic write_length(input logic [13:0] len);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_table_length <= len;
        do @(posedge aclk); while (!cfg_ready);
        cur_length = len;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one index beat and record its expected coefficient on acceptance
    task automatic send_index(input logic [13:0] idx, input bit known, input coef_beat_t typed);
        coef_beat_t exp_beat;
        exp_beat = windowed_sinc(cur_length, idx);
        if (known && exp_beat != typed)
            $error("typed row disagrees with predictor: idx=%0d exp=%h pred=%h",
                   idx, typed, exp_beat);
        s_valid <= 1'b1;
        s_index <= idx;
        do @(posedge aclk); while (!s_ready);
        coef_due_q.push_back(exp_beat);
        @(negedge aclk);
    endtask

    // Sender idles between beats; valid only drops when a gap is taken
    task automatic idle_sender();
        int g;
        g = gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    // Drive the receiver: random stalls plus one long hold-off on request
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off_req = 0;
            end
            g = gap_len();
            if (g != 0) begin
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge aclk) begin
        coef_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (coef_due_q.size() == 0) begin
                $error("result beat with nothing expected: coef=%0d err=%0b",
                       m_coefficient, m_length_error);
                fail_count++;
            end else begin
                want = coef_due_q.pop_front();
                if (m_coefficient !== want.coefficient) begin
                    $error("coefficient mismatch: expected %0d, actual %0d",
                           want.coefficient, m_coefficient);
                    fail_count++;
                end
                if (m_length_error !== want.length_error) begin
                    $error("length_error mismatch: expected %0b, actual %0b",
                           want.length_error, m_length_error);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        row_t rows[$];
        coef_beat_t typed;
        logic [13:0] lens[10];
        logic [13:0] len, idx;
        int p;
        fail_count = 0;
        beats_seen = 0;
        hold_off_req = 0;
        cur_length = 14'd2047;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_table_length = '0;
        s_valid = 1'b0;
        s_index = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset length, centre, ends, bad lengths and indices
        rows.push_back('{14'd0, 14'd1023, 1'b1, 16'sh7fff, 1'b0});
        rows.push_back('{14'd0, 14'd0, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd2046, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd2047, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd0, 14'h3fff, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd3, 14'd0, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd1, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd2, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd3, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd1, 14'd0, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd2, 14'd0, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd2, 14'd1, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd16382, 14'd5, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd16383, 14'd8191, 1'b1, 16'sh7fff, 1'b0});
        rows.push_back('{14'd0, 14'd0, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd16382, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd8190, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd16383, 1'b1, 16'sd0, 1'b1});
        rows.push_back('{14'd5, 14'd1, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd4, 1'b0, 16'sd0, 1'b0});
        rows.push_back('{14'd0, 14'd2, 1'b0, 16'sd0, 1'b0});

        foreach (rows[i]) begin
            if (rows[i].length != 0) begin
                s_valid <= 1'b0;
                write_length(rows[i].length);
            end
            typed.coefficient = rows[i].coefficient;
            typed.length_error = rows[i].length_error;
            send_index(rows[i].index, rows[i].known, typed);
            idle_sender();
        end

        // Random phases over a spread of lengths, mostly odd and in range
        lens = '{14'd3, 14'd16383, 14'd7, 14'd101, 14'd2047,
                 14'd16382, 14'd4, 14'd1, 14'd9999, 14'd255};
        for (int ph = 0; ph < 10; ph++) begin
            s_valid <= 1'b0;
            len = lens[ph];
            if (ph == 3) len = $urandom_range(1, 16383);
            write_length(len);
            for (int k = 0; k < 180; k++) begin
                if (ph == 1 && k == 20) hold_off_req = 1;
                p = $urandom_range(0, 99);
                if (p < 85 && len > 0) idx = $urandom_range(0, len - 1);
                else idx = $urandom_range(0, 16383);
                if (k % 97 == 0) idx = ~idx;
                send_index(idx, 1'b0, '0);
                if (!(ph == 1 && k < 120)) idle_sender();
            end
        end
        s_valid <= 1'b0;

        wait_drained();
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
